>>> src/segment_convex_polygon_clipper_macros.svh
// Assertion macros for the convex polygon segment clipper.
// Included by the top level; no other dependencies.
`ifndef SEGMENT_CONVEX_POLYGON_CLIPPER_MACROS_SVH
`define SEGMENT_CONVEX_POLYGON_CLIPPER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on every rising edge out of reset
`define SCPC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scpc assertion failed");
// next-cycle implication
`define SCPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scpc assertion failed");
`else
`define SCPC_ASSERT_NOW(label, ante, cons)
`define SCPC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> src/scpc_pkg.sv
// Shared types and constants of the convex polygon segment clipper.
// No dependencies; imported by every module of the block.
package scpc_pkg;

    // fixed field widths
    localparam int COORD_W      = 32;
    localparam int VIDX_W       = 6;
    localparam int CNT_W        = 7;
    localparam int MAX_VERTICES = 64;

    // derived widths
    localparam int IDX_W  = $clog2(MAX_VERTICES);
    localparam int N_W    = $clog2(MAX_VERTICES + 1);
    localparam int DIF_W  = COORD_W + 1;          // coordinate difference
    localparam int PROD_W = 2 * DIF_W;            // one cross-product term
    localparam int D_W    = PROD_W + 1;           // side test value
    localparam int QCNT_W = $clog2(COORD_W);      // divider bit counter

    // opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CLIP  = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_vtx;

    // cross-product unit control
    typedef struct packed {
        logic edge_ld;   // load edge vector and base vertex
        logic mul_en;    // run the multiplier
        logic term;      // 0: edx*ry, 1: edy*rx
        logic pt_e;      // 0: start point, 1: end point
        logic dif_en;    // form side value from the two terms
        logic dif_e;     // 0: start side value, 1: end side value
    } t_side_ctl;

endpackage

>>> src/scpc_side.sv
// Side test unit: one shared signed multiplier computing cross(B-A, P-A).
// Depends on scpc_pkg.
module scpc_side
    import scpc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_side_ctl                 i_ctl,
    input  t_vtx                      i_va,
    input  t_vtx                      i_vb,
    input  t_vtx                      i_ps,
    input  t_vtx                      i_pe,
    output logic signed [D_W-1:0]     o_ds,
    output logic signed [D_W-1:0]     o_de
);

    logic signed [DIF_W-1:0]   r_edx, r_edy;
    logic signed [COORD_W-1:0] r_ax, r_ay;
    logic signed [PROD_W-1:0]  r_prod, r_t1;
    logic signed [D_W-1:0]     r_ds, r_de;
    t_vtx                      pt;
    logic signed [DIF_W-1:0]   rx, ry, op_a, op_b;
    logic signed [D_W-1:0]     dif;

    // point relative to the edge base
    assign pt   = i_ctl.pt_e ? i_pe : i_ps;
    assign rx   = $signed({pt.x[COORD_W-1], pt.x}) - $signed({r_ax[COORD_W-1], r_ax});
    assign ry   = $signed({pt.y[COORD_W-1], pt.y}) - $signed({r_ay[COORD_W-1], r_ay});
    assign op_a = i_ctl.term ? r_edy : r_edx;
    assign op_b = i_ctl.term ? rx : ry;
    assign dif  = $signed({r_t1[PROD_W-1], r_t1}) - $signed({r_prod[PROD_W-1], r_prod});

    // edge vector
    always_ff @(posedge i_clk) begin
        if (i_ctl.edge_ld) begin
            r_ax  <= i_va.x;
            r_ay  <= i_va.y;
            r_edx <= $signed({i_vb.x[COORD_W-1], i_vb.x}) - $signed({i_va.x[COORD_W-1], i_va.x});
            r_edy <= $signed({i_vb.y[COORD_W-1], i_vb.y}) - $signed({i_va.y[COORD_W-1], i_va.y});
        end
    end

    // shared multiplier, first term held while the second is formed
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= op_a * op_b;
            if (i_ctl.term) begin
                r_t1 <= r_prod;
            end
        end
        if (i_ctl.dif_en) begin
            if (i_ctl.dif_e) begin
                r_de <= dif;
            end else begin
                r_ds <= dif;
            end
        end
    end

    // reset clears r_seen, which holds both side values at zero until the first edge load
    logic r_seen;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (i_ctl.edge_ld) begin
            r_seen <= 1'b1;
        end
    end

    assign o_ds = r_seen ? r_ds : '0;
    assign o_de = r_seen ? r_de : '0;

endmodule

>>> src/scpc_muldiv.sv
// Bit-serial scaled quotient floor(m * a / den) with a <= den, a doubling step then an add step for each bit of m.
// Depends on scpc_pkg.
module scpc_muldiv
    import scpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [COORD_W-1:0]   i_m,
    input  logic [D_W-1:0]       i_a,
    input  logic [D_W-1:0]       i_den,
    output logic                 o_busy,
    output logic                 o_done,
    output logic [COORD_W-1:0]   o_q
);

    logic                r_busy, r_done, r_ph;
    logic [QCNT_W-1:0]   r_cnt;
    logic [COORD_W-1:0]  r_m, r_q;
    logic [D_W-1:0]      r_r;
    logic [D_W:0]        s, den_x;
    logic                ge;

    // invariant: prefix(m) * a == q * den + r, r < den
    assign den_x = {1'b0, i_den};
    assign s     = r_ph ? ({1'b0, r_r} + (r_m[COORD_W-1] ? {1'b0, i_a} : '0))
                        : {r_r, 1'b0};
    assign ge    = (s >= den_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_ph   <= 1'b0;
                r_cnt  <= QCNT_W'(COORD_W - 1);
                r_m    <= i_m;
                r_q    <= '0;
                r_r    <= '0;
            end else if (r_busy) begin
                r_r <= ge ? D_W'(s - den_x) : s[D_W-1:0];
                if (!r_ph) begin
                    // double: shift quotient in
                    r_q  <= {r_q[COORD_W-2:0], ge};
                    r_ph <= 1'b1;
                end else begin
                    // add a if the current bit of m is set
                    r_q  <= r_q + COORD_W'(ge);
                    r_m  <= {r_m[COORD_W-2:0], 1'b0};
                    r_ph <= 1'b0;
                    if (r_cnt == '0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

>>> src/segment_convex_polygon_clipper.sv
// Convex polygon segment clipper, top level: vertex table, sequencer, result register.
// Depends on scpc_pkg, scpc_side, scpc_muldiv and segment_convex_polygon_clipper_macros.svh.
//
// Loads up to 64 counter-clockwise polygon vertices (opcode 0) and clips segments against
// them (opcode 1). A clip walks the edges one at a time: each edge goes through a vertex
// read, four passes of the shared 33x33 multiplier and a decision, and every time an
// endpoint moves to an intersection the bit-serial interpolation divider runs, with a
// doubling step and an add step per coordinate bit, x then y. With zero vertices the
// segment comes back unchanged. The input is not ready during a clip; a finished result
// waits in the output register without blocking the next item.
`include "segment_convex_polygon_clipper_macros.svh"

module segment_convex_polygon_clipper
    import scpc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CNT_W-1:0]           i_cfg_wdata,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_opcode,
    input  logic [VIDX_W-1:0]          i_vertex_index,
    input  logic signed [COORD_W-1:0]  i_start_x,
    input  logic signed [COORD_W-1:0]  i_start_y,
    input  logic signed [COORD_W-1:0]  i_end_x,
    input  logic signed [COORD_W-1:0]  i_end_y,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_inside_hit,
    output logic signed [COORD_W-1:0]  o_clip_start_x,
    output logic signed [COORD_W-1:0]  o_clip_start_y,
    output logic signed [COORD_W-1:0]  o_clip_end_x,
    output logic signed [COORD_W-1:0]  o_clip_end_y
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RD0  = 4'd1;
    localparam logic [3:0] ST_RDB  = 4'd2;
    localparam logic [3:0] ST_M1   = 4'd3;
    localparam logic [3:0] ST_M2   = 4'd4;
    localparam logic [3:0] ST_M3   = 4'd5;
    localparam logic [3:0] ST_M4   = 4'd6;
    localparam logic [3:0] ST_M5   = 4'd7;
    localparam logic [3:0] ST_CHK  = 4'd8;
    localparam logic [3:0] ST_DEN  = 4'd9;
    localparam logic [3:0] ST_MVX  = 4'd10;
    localparam logic [3:0] ST_WX   = 4'd11;
    localparam logic [3:0] ST_MVY  = 4'd12;
    localparam logic [3:0] ST_WY   = 4'd13;
    localparam logic [3:0] ST_NEXT = 4'd14;
    localparam logic [3:0] ST_FIN  = 4'd15;

    logic [3:0]           r_state;
    logic [CNT_W-1:0]     r_count;
    logic [N_W-1:0]       r_n;
    logic [IDX_W-1:0]     r_k;
    t_vtx                 r_s, r_e, r_va, r_rdata;
    logic                 r_hit, r_mv_s, r_neg;
    logic [D_W-1:0]       r_a, r_den;

    t_vtx                 mem [MAX_VERTICES];
    logic [IDX_W-1:0]     rd_addr;
    logic                 in_acc, wr_en;
    logic [N_W-1:0]       n_sat, k1, k2;
    t_side_ctl            side_ctl;
    logic signed [D_W-1:0] ds, de;
    logic                 div_start, div_busy, div_done;
    logic [COORD_W-1:0]   div_q, mag;
    logic signed [COORD_W-1:0] o_c, i_c, moved;
    logic signed [DIF_W-1:0]   dif_io, mag_x;
    logic                 out_load;

    assign o_ready = (r_state == ST_IDLE);
    assign in_acc  = i_valid && o_ready;
    assign wr_en   = in_acc && (i_opcode == OP_WRITE)
                     && (int'(i_vertex_index) < MAX_VERTICES);

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    assign n_sat = (int'(r_count) > MAX_VERTICES) ? N_W'(MAX_VERTICES) : N_W'(r_count);
    assign k1    = N_W'(r_k) + N_W'(1);
    assign k2    = N_W'(r_k) + N_W'(2);

    // vertex read address: first vertex, then the far end of each edge
    always_comb begin
        unique case (r_state)
            ST_RD0:  rd_addr = (r_n == N_W'(1)) ? '0 : IDX_W'(1);
            ST_NEXT: rd_addr = (k2 == r_n) ? '0 : k2[IDX_W-1:0];
            default: rd_addr = '0;
        endcase
    end

    // vertex table
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[IDX_W'(i_vertex_index)] <= '{x: i_start_x, y: i_start_y};
        end
        r_rdata <= mem[rd_addr];
    end

    // cross-product unit control
    always_comb begin
        side_ctl = '0;
        unique case (r_state)
            ST_RDB: side_ctl.edge_ld = 1'b1;
            ST_M1:  side_ctl.mul_en  = 1'b1;
            ST_M2: begin
                side_ctl.mul_en = 1'b1;
                side_ctl.term   = 1'b1;
            end
            ST_M3: begin
                side_ctl.mul_en = 1'b1;
                side_ctl.pt_e   = 1'b1;
                side_ctl.dif_en = 1'b1;
            end
            ST_M4: begin
                side_ctl.mul_en = 1'b1;
                side_ctl.term   = 1'b1;
                side_ctl.pt_e   = 1'b1;
            end
            ST_M5: begin
                side_ctl.dif_en = 1'b1;
                side_ctl.dif_e  = 1'b1;
            end
            default: side_ctl = '0;
        endcase
    end

    scpc_side u_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (side_ctl),
        .i_va    (r_va),
        .i_vb    (r_rdata),
        .i_ps    (r_s),
        .i_pe    (r_e),
        .o_ds    (ds),
        .o_de    (de)
    );

    // moving coordinate: outside point o_c toward inside point i_c
    always_comb begin
        if (r_state == ST_MVY || r_state == ST_WY) begin
            o_c = r_mv_s ? r_s.y : r_e.y;
            i_c = r_mv_s ? r_e.y : r_s.y;
        end else begin
            o_c = r_mv_s ? r_s.x : r_e.x;
            i_c = r_mv_s ? r_e.x : r_s.x;
        end
    end
    assign dif_io = $signed({i_c[COORD_W-1], i_c}) - $signed({o_c[COORD_W-1], o_c});
    assign mag_x  = dif_io[DIF_W-1] ? -dif_io : dif_io;
    assign mag    = mag_x[COORD_W-1:0];
    assign moved  = r_neg ? (o_c - $signed(div_q)) : (o_c + $signed(div_q));

    assign div_start = (r_state == ST_MVX) || (r_state == ST_MVY);

    scpc_muldiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_m     (mag),
        .i_a     (r_a),
        .i_den   (r_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    assign out_load = (r_state == ST_FIN) && (!o_valid || i_ready);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc && (i_opcode == OP_CLIP)) begin
                        r_s   <= '{x: i_start_x, y: i_start_y};
                        r_e   <= '{x: i_end_x, y: i_end_y};
                        r_n   <= n_sat;
                        r_k   <= '0;
                        r_hit <= 1'b1;
                        r_state <= (n_sat == '0) ? ST_FIN : ST_RD0;
                    end
                end
                ST_RD0: begin
                    r_va    <= r_rdata;
                    r_state <= ST_RDB;
                end
                ST_RDB: begin
                    r_va    <= r_rdata;
                    r_state <= ST_M1;
                end
                ST_M1: r_state <= ST_M2;
                ST_M2: r_state <= ST_M3;
                ST_M3: r_state <= ST_M4;
                ST_M4: r_state <= ST_M5;
                ST_M5: r_state <= ST_CHK;
                ST_CHK: begin
                    priority if (ds[D_W-1] && de[D_W-1]) begin
                        r_hit   <= 1'b0;
                        r_state <= ST_FIN;
                    end else if (ds[D_W-1]) begin
                        r_mv_s  <= 1'b1;
                        r_state <= ST_DEN;
                    end else if (de[D_W-1]) begin
                        r_mv_s  <= 1'b0;
                        r_state <= ST_DEN;
                    end else begin
                        r_state <= ST_NEXT;
                    end
                end
                ST_DEN: begin
                    // a = |d_out|, den = d_in - d_out
                    r_a     <= r_mv_s ? D_W'(-ds) : D_W'(-de);
                    r_den   <= r_mv_s ? D_W'(de - ds) : D_W'(ds - de);
                    r_state <= ST_MVX;
                end
                ST_MVX: begin
                    r_neg   <= dif_io[DIF_W-1];
                    r_state <= ST_WX;
                end
                ST_WX: begin
                    if (div_done) begin
                        if (r_mv_s) begin
                            r_s.x <= moved;
                        end else begin
                            r_e.x <= moved;
                        end
                        r_state <= ST_MVY;
                    end
                end
                ST_MVY: begin
                    r_neg   <= dif_io[DIF_W-1];
                    r_state <= ST_WY;
                end
                ST_WY: begin
                    if (div_done) begin
                        if (r_mv_s) begin
                            r_s.y <= moved;
                        end else begin
                            r_e.y <= moved;
                        end
                        r_state <= ST_NEXT;
                    end
                end
                ST_NEXT: begin
                    if (k1 == r_n) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_k     <= k1[IDX_W-1:0];
                        r_state <= ST_RDB;
                    end
                end
                ST_FIN: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (out_load) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_inside_hit   <= r_hit;
            o_clip_start_x <= r_hit ? r_s.x : '0;
            o_clip_start_y <= r_hit ? r_s.y : '0;
            o_clip_end_x   <= r_hit ? r_e.x : '0;
            o_clip_end_y   <= r_hit ? r_e.y : '0;
        end
    end

    // checks
    `SCPC_ASSERT_NOW(a_miss_zero, o_valid && !o_inside_hit, o_clip_start_x == '0 && o_clip_start_y == '0 && o_clip_end_x == '0 && o_clip_end_y == '0)
    `SCPC_ASSERT_NOW(a_div_idle_start, div_start, !div_busy)
    `SCPC_ASSERT_NOW(a_div_done_wait, div_done, r_state == ST_WX || r_state == ST_WY)
    `SCPC_ASSERT_NEXT(a_clip_blocks, in_acc && (i_opcode == OP_CLIP), !o_ready)

endmodule

>>> sim/tb_segment_convex_polygon_clipper.sv
// Self-checking testbench for segment_convex_polygon_clipper: loads convex polygons,
// clips directed and random segments, and checks every clip transaction against a
// bit-exact predictor. Depends on scpc_pkg and the clipper RTL.
`timescale 1ns / 100ps

module tb_segment_convex_polygon_clipper;
    import scpc_pkg::*;

    localparam int  ITEM_TARGET  = 530;
    localparam int  PROFILE_SWAP = 190;
    localparam int  PROFILE_CALM = 380;
    localparam int  LIMIT_CYCLES = 30000000;
    localparam int  WIDE_W       = 72;
    localparam real PI           = 3.14159265358979;

    localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] UNIT  = 32'sd65536;
    localparam logic signed [COORD_W-1:0] HALF  = 32'sd655360;   // 10.0 in Q16.16

    typedef logic signed [WIDE_W-1:0] t_wide;

    typedef struct packed {
        logic                      op;
        logic [VIDX_W-1:0]         slot;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
    } t_clip_item;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
    } t_clip_result;

    // Polygon table, vertex count and the queue of clip results still owed by the block
    class polygon_clip_tracker;
        t_vtx         vtx_table [MAX_VERTICES];
        int           count_reg;
        t_clip_result expected_clips [$];
        int           errors;

        function new();
            count_reg = 0;
            errors    = 0;
            foreach (vtx_table[k]) vtx_table[k] = '0;
        endfunction

        function void set_vertex_count(logic [CNT_W-1:0] value);
            count_reg = value;
        endfunction

        function int vertices_in_use();
            return (count_reg > MAX_VERTICES) ? MAX_VERTICES : count_reg;
        endfunction

        function int pending();
            return expected_clips.size();
        endfunction

        // cross(B - A, P - A), exact
        function t_wide side_test(t_vtx a, t_vtx b, logic signed [COORD_W-1:0] px,
                                  logic signed [COORD_W-1:0] py);
            t_wide edx, edy, rdx, rdy;
            edx = t_wide'(b.x) - t_wide'(a.x);
            edy = t_wide'(b.y) - t_wide'(a.y);
            rdx = t_wide'(px) - t_wide'(a.x);
            rdy = t_wide'(py) - t_wide'(a.y);
            return edx * rdy - edy * rdx;
        endfunction

        // outside coordinate moves toward the inside one, truncated toward the outside
        function logic signed [COORD_W-1:0] slide_coord(logic signed [COORD_W-1:0] o,
                                                        logic signed [COORD_W-1:0] i,
                                                        logic [WIDE_W-1:0] d_out,
                                                        logic [WIDE_W-1:0] d_sum);
            t_wide                 gap;
            logic [WIDE_W-1:0]     gap_mag;
            logic [2*WIDE_W-1:0]   num, quo;
            gap     = t_wide'(i) - t_wide'(o);
            gap_mag = (gap < 0) ? -gap : gap;
            num     = {{WIDE_W{1'b0}}, gap_mag} * {{WIDE_W{1'b0}}, d_out};
            quo     = num / {{WIDE_W{1'b0}}, d_sum};
            return (gap < 0) ? o - quo[COORD_W-1:0] : o + quo[COORD_W-1:0];
        endfunction

        function t_clip_result clip_segment(logic signed [COORD_W-1:0] sx,
                                            logic signed [COORD_W-1:0] sy,
                                            logic signed [COORD_W-1:0] ex,
                                            logic signed [COORD_W-1:0] ey);
            t_clip_result      res;
            t_wide             d_s, d_e;
            logic [WIDE_W-1:0] d_sum;
            t_vtx              va, vb;
            int                n;
            n       = vertices_in_use();
            res     = '0;
            res.hit = 1'b1;
            for (int k = 0; k < n; k++) begin
                va  = vtx_table[k];
                vb  = vtx_table[(k + 1 == n) ? 0 : k + 1];
                d_s = side_test(va, vb, sx, sy);
                d_e = side_test(va, vb, ex, ey);
                if (d_s < 0 && d_e < 0) begin
                    res.hit = 1'b0;
                    break;
                end
                if (d_s < 0) begin
                    d_sum = -d_s + d_e;
                    sx    = slide_coord(sx, ex, -d_s, d_sum);
                    sy    = slide_coord(sy, ey, -d_s, d_sum);
                end else if (d_e < 0) begin
                    d_sum = -d_e + d_s;
                    ex    = slide_coord(ex, sx, -d_e, d_sum);
                    ey    = slide_coord(ey, sy, -d_e, d_sum);
                end
            end
            if (res.hit) begin
                res.sx = sx;
                res.sy = sy;
                res.ex = ex;
                res.ey = ey;
            end
            return res;
        endfunction

        function void note_item(t_clip_item it);
            if (it.op == OP_WRITE) begin
                vtx_table[it.slot].x = it.sx;
                vtx_table[it.slot].y = it.sy;
            end else begin
                expected_clips.insert(expected_clips.size(),
                                      clip_segment(it.sx, it.sy, it.ex, it.ey));
            end
        endfunction

        function void compare_coord(string name, logic signed [COORD_W-1:0] want,
                                    logic signed [COORD_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_clip_result got);
            t_clip_result want;
            if (expected_clips.size() == 0) begin
                $error("clip result with nothing outstanding: inside_hit %0b", got.hit);
                errors++;
                return;
            end
            want = expected_clips.pop_front();
            if (got.hit !== want.hit) begin
                $error("inside_hit: expected %0b, got %0b", want.hit, got.hit);
                errors++;
            end
            compare_coord("clip_start_x", want.sx, got.sx);
            compare_coord("clip_start_y", want.sy, got.sy);
            compare_coord("clip_end_x", want.ex, got.ex);
            compare_coord("clip_end_y", want.ey, got.ey);
        endfunction
    endclass

    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      i_cfg_we       = 1'b0;
    logic [CNT_W-1:0]          i_cfg_wdata    = '0;
    logic                      i_valid        = 1'b0;
    logic                      o_ready;
    logic                      i_opcode       = OP_WRITE;
    logic [VIDX_W-1:0]         i_vertex_index = '0;
    logic signed [COORD_W-1:0] i_start_x      = '0;
    logic signed [COORD_W-1:0] i_start_y      = '0;
    logic signed [COORD_W-1:0] i_end_x        = '0;
    logic signed [COORD_W-1:0] i_end_y        = '0;
    logic                      o_valid;
    logic                      i_ready        = 1'b0;
    logic                      o_inside_hit;
    logic signed [COORD_W-1:0] o_clip_start_x;
    logic signed [COORD_W-1:0] o_clip_start_y;
    logic signed [COORD_W-1:0] o_clip_end_x;
    logic signed [COORD_W-1:0] o_clip_end_y;

    polygon_clip_tracker tracker = new();

    int send_idle_pct = 17;
    int recv_idle_pct = 50;
    int items_sent    = 0;
    int cycle_count   = 0;

    // current random polygon: center and radius
    int poly_cx = 0;
    int poly_cy = 0;
    int poly_r  = 1 << 20;

    segment_convex_polygon_clipper dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_vertex_index (i_vertex_index),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_inside_hit   (o_inside_hit),
        .o_clip_start_x (o_clip_start_x),
        .o_clip_start_y (o_clip_start_y),
        .o_clip_end_x   (o_clip_end_x),
        .o_clip_end_y   (o_clip_end_y)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("tb_segment_convex_polygon_clipper: done, errors");
            $finish;
        end
    end

    // result side: check on handshake, random backpressure
    initial begin
        t_clip_result seen;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                seen = {o_inside_hit, o_clip_start_x, o_clip_start_y,
                        o_clip_end_x, o_clip_end_y};
                tracker.check_result(seen);
            end
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // one input transaction, with an optional idle gap in front
    task automatic offer_item(t_clip_item it);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid        <= 1'b1;
        i_opcode       <= it.op;
        i_vertex_index <= it.slot;
        i_start_x      <= it.sx;
        i_start_y      <= it.sy;
        i_end_x        <= it.ex;
        i_end_y        <= it.ey;
        do @(posedge i_clk); while (!o_ready);
        tracker.note_item(it);
        items_sent++;
        if (items_sent == PROFILE_SWAP) begin
            send_idle_pct = 50;
            recv_idle_pct = 17;
        end else if (items_sent == PROFILE_CALM) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    task automatic send_vertex(int slot, logic signed [COORD_W-1:0] x,
                               logic signed [COORD_W-1:0] y);
        t_clip_item it;
        it.op   = OP_WRITE;
        it.slot = VIDX_W'(slot);
        it.sx   = x;
        it.sy   = y;
        it.ex   = $urandom;    // don't-care on a vertex write
        it.ey   = $urandom;
        offer_item(it);
    endtask

    task automatic send_segment(logic signed [COORD_W-1:0] sx, logic signed [COORD_W-1:0] sy,
                                logic signed [COORD_W-1:0] ex, logic signed [COORD_W-1:0] ey);
        t_clip_item it;
        it.op   = OP_CLIP;
        it.slot = VIDX_W'($urandom);
        it.sx   = sx;
        it.sy   = sy;
        it.ex   = ex;
        it.ey   = ey;
        offer_item(it);
    endtask

    // hold off input until every owed clip result is back, then settle
    task automatic wait_idle(int settle);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_vertex_count(int value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CNT_W'(value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.set_vertex_count(CNT_W'(value));
    endtask

    // CCW convex polygon: jittered angles around a circle
    task automatic load_polygon(int n);
        real    step, ang;
        longint px, py;
        step = 2.0 * PI / n;
        for (int k = 0; k < n; k++) begin
            ang = step * (k + 0.8 * ($urandom_range(1000) / 1000.0) - 0.4);
            px  = poly_cx + $rtoi(poly_r * $cos(ang));
            py  = poly_cy + $rtoi(poly_r * $sin(ang));
            send_vertex(k, px[COORD_W-1:0], py[COORD_W-1:0]);
        end
    endtask

    // endpoint: mostly near the polygon, sometimes a vertex, sometimes anywhere
    function automatic void pick_point(output logic signed [COORD_W-1:0] px,
                                       output logic signed [COORD_W-1:0] py);
        int     mode, n;
        longint span, x, y;
        t_vtx   v;
        mode = $urandom_range(19);
        n    = tracker.vertices_in_use();
        if (mode == 0) begin
            px = $urandom;
            py = $urandom;
        end else if (mode <= 2 && n > 0) begin
            v  = tracker.vtx_table[$urandom_range(n - 1)];
            px = v.x;
            py = v.y;
        end else begin
            span = (mode < 10) ? poly_r : 2 * poly_r;
            x    = poly_cx + longint'($urandom_range(2 * span)) - span;
            y    = poly_cy + longint'($urandom_range(2 * span)) - span;
            px   = x[COORD_W-1:0];
            py   = y[COORD_W-1:0];
        end
    endfunction

    task automatic random_clip();
        logic signed [COORD_W-1:0] sx, sy, ex, ey;
        pick_point(sx, sy);
        if ($urandom_range(11) == 0) begin
            ex = sx;    // degenerate segment
            ey = sy;
        end else begin
            pick_point(ex, ey);
        end
        send_segment(sx, sy, ex, ey);
    endtask

    // main sequence
    initial begin
        int phase, n_poly, cfg_val, n_clips, slot;
        bit reload;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no vertices: segments pass unchanged
        send_segment(C_MAX, C_MIN, C_MIN, C_MAX);
        send_segment(C_MIN, C_MIN, C_MAX, C_MAX);

        // full-range square
        send_vertex(0, C_MIN, C_MIN);
        send_vertex(1, C_MAX, C_MIN);
        send_vertex(2, C_MAX, C_MAX);
        send_vertex(3, C_MIN, C_MAX);
        wait_idle(8);
        write_vertex_count(4);
        send_segment(C_MIN, C_MAX, C_MAX, C_MIN);
        send_segment('0, '0, '0, '0);

        // 20x20 square around the origin
        send_vertex(0, -HALF, -HALF);
        send_vertex(1, HALF, -HALF);
        send_vertex(2, HALF, HALF);
        send_vertex(3, -HALF, HALF);
        send_segment(-UNIT, '0, UNIT, 2 * UNIT);                  // fully inside
        send_segment(-20 * UNIT, 3 * UNIT, '0, '0);               // start outside
        send_segment('0, '0, 7 * UNIT, 30 * UNIT);                // end outside
        send_segment(-30 * UNIT, -1, 30 * UNIT, 5 * UNIT + 3);    // crosses both sides
        send_segment(-30 * UNIT, '0, -15 * UNIT, 40 * UNIT);      // miss
        send_segment(-16 * UNIT, 4 * UNIT, 4 * UNIT, 16 * UNIT);  // cuts across a corner
        send_segment(C_MAX, C_MAX, C_MAX, C_MAX);                 // degenerate, outside
        send_segment(HALF, HALF, HALF, HALF);                     // degenerate, on a vertex
        send_segment(C_MIN, C_MIN, C_MAX, C_MAX);                 // extreme products

        // single vertex: null edge
        wait_idle(8);
        write_vertex_count(1);
        send_segment(C_MIN, C_MAX, C_MAX, C_MIN);

        // two vertices: only the line y = -10 survives
        wait_idle(8);
        write_vertex_count(2);
        send_segment('0, -30 * UNIT, '0, 30 * UNIT);
        send_segment(-3 * UNIT, -HALF, 4 * UNIT, -HALF);

        // random phases, each with its own polygon and count
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            reload  = 1'b1;
            poly_cx = int'($urandom_range(1 << 21)) - (1 << 20);
            poly_cy = int'($urandom_range(1 << 21)) - (1 << 20);
            poly_r  = (1 << $urandom_range(12, 27)) + $urandom_range(1 << 12);
            case (phase)
                0: n_poly = MAX_VERTICES;
                1: begin
                    n_poly = MAX_VERTICES;    // count above the table saturates
                    reload = 1'b0;
                end
                2: n_poly = 0;
                3: n_poly = 1;
                4: n_poly = 2;
                default: begin
                    case ($urandom_range(9))
                        7:       n_poly = $urandom_range(9, 16);
                        8:       n_poly = $urandom_range(0, 2);
                        9:       n_poly = $urandom_range(20, 40);
                        default: n_poly = $urandom_range(3, 8);
                    endcase
                end
            endcase
            if (phase == 1) begin
                cfg_val = (1 << CNT_W) - 1;
                // the previous polygon stays loaded; point picking uses a center and radius set here
                poly_cx = tracker.vtx_table[0].x / 2;
                poly_cy = 0;
                poly_r  = 1 << 20;
            end else begin
                cfg_val = n_poly;
            end
            if (reload && n_poly > 0) load_polygon(n_poly);
            wait_idle(8);
            write_vertex_count(cfg_val);

            n_clips = (n_poly >= 20) ? $urandom_range(10, 18) : $urandom_range(15, 35);
            for (int c = 0; c < n_clips; c++) begin
                // stray write to a slot outside the active polygon
                if (n_poly < MAX_VERTICES && $urandom_range(14) == 0) begin
                    slot = $urandom_range(n_poly, MAX_VERTICES - 1);
                    send_vertex(slot, $urandom, $urandom);
                end
                if ($urandom_range(39) == 0) wait_idle(0);
                random_clip();
            end
            phase++;
        end

        wait_idle(50);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("tb_segment_convex_polygon_clipper: done, clean");
        end else begin
            $display("tb_segment_convex_polygon_clipper: done, errors");
        end
        $finish;
    end

endmodule
